@@ rtl/tcspq_pkg.sv @@
package tcspq_pkg;

   // Widths of the item fields.
   localparam int OPCODE_BITS = 2;
   localparam int ITEM_ID_BITS = 16;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMMIT
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic latch;
      logic read_head;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/tcspq_ctrl.sv @@
module tcspq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  tcspq_pkg::dp_status_type dp_status,
   output tcspq_pkg::ctl_cmd_type   cmd
);

   tcspq_pkg::state_type state_ff;
   tcspq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcspq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcspq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = tcspq_pkg::ST_READ;
            end
         end
         tcspq_pkg::ST_READ: begin
            state_in = tcspq_pkg::ST_COMMIT;
         end
         tcspq_pkg::ST_COMMIT: begin
            if (dp_status.out_free) begin
               state_in = tcspq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcspq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.latch     = 1'b0;
      cmd.read_head = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         tcspq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         tcspq_pkg::ST_READ: begin
            cmd.read_head = 1'b1;
         end
         tcspq_pkg::ST_COMMIT: begin
            cmd.commit = dp_status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/tcspq_dpath.sv @@
module tcspq_dpath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcspq_pkg::ctl_cmd_type                cmd,
   output tcspq_pkg::dp_status_type              dp_status,
   input  logic [tcspq_pkg::OPCODE_BITS-1:0]     req_opcode,
   input  logic                                  req_item_class,
   input  logic [tcspq_pkg::ITEM_ID_BITS-1:0]    req_item_id,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tcspq_pkg::ITEM_ID_BITS-1:0]    rsp_out_id,
   output logic                                  rsp_out_class,
   output logic [tcspq_pkg::STATUS_BITS-1:0]     rsp_status
);

   // Identifiers are carried on 16 bits, so no more than that is ever stored.
   localparam int STORE_BITS = (ID_BITS < tcspq_pkg::ITEM_ID_BITS) ?
                               ID_BITS : tcspq_pkg::ITEM_ID_BITS;
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   // Request registers.
   tcspq_pkg::opcode_type   op_ff;
   logic                    cls_ff;
   logic [STORE_BITS-1:0]   id_ff;

   // FIFO pointers and fill counts.
   logic [PTR_BITS-1:0] urg_head_ff, urg_head_in, urg_tail_ff, urg_tail_in;
   logic [PTR_BITS-1:0] nrm_head_ff, nrm_head_in, nrm_tail_ff, nrm_tail_in;
   logic [CNT_BITS-1:0] urg_cnt_ff, urg_cnt_in, nrm_cnt_ff, nrm_cnt_in;

   // Storage and registered head reads.
   logic [STORE_BITS-1:0] urg_mem [QUEUE_DEPTH];
   logic [STORE_BITS-1:0] nrm_mem [QUEUE_DEPTH];
   logic [STORE_BITS-1:0] urg_rd_ff, nrm_rd_ff;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [tcspq_pkg::ITEM_ID_BITS-1:0]   out_id_ff, out_id_in;
   logic                                 out_class_ff, out_class_in;
   tcspq_pkg::status_type                status_ff, status_in;

   logic urg_we, nrm_we;

   assign dp_status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= tcspq_pkg::opcode_type'(req_opcode);
         cls_ff <= req_item_class;
         id_ff  <= STORE_BITS'(req_item_id);
      end
   end

   always_ff @(posedge clock) begin
      if (urg_we) begin
         urg_mem[urg_tail_ff] <= id_ff;
      end
      if (nrm_we) begin
         nrm_mem[nrm_tail_ff] <= id_ff;
      end
      if (cmd.read_head) begin
         urg_rd_ff <= urg_mem[urg_head_ff];
         nrm_rd_ff <= nrm_mem[nrm_head_ff];
      end
   end

   always_comb begin
      urg_head_in  = urg_head_ff;
      urg_tail_in  = urg_tail_ff;
      urg_cnt_in   = urg_cnt_ff;
      nrm_head_in  = nrm_head_ff;
      nrm_tail_in  = nrm_tail_ff;
      nrm_cnt_in   = nrm_cnt_ff;
      urg_we       = 1'b0;
      nrm_we       = 1'b0;
      out_id_in    = '0;
      out_class_in = 1'b0;
      status_in    = tcspq_pkg::STATUS_OK;
      unique case (op_ff)
         tcspq_pkg::OP_ENQUEUE: begin
            if (cls_ff) begin
               if (urg_cnt_ff == CNT_FULL) begin
                  status_in = tcspq_pkg::STATUS_FULL;
               end else begin
                  urg_we      = 1'b1;
                  urg_tail_in = (urg_tail_ff == PTR_LAST) ? '0 :
                                urg_tail_ff + PTR_BITS'(1);
                  urg_cnt_in  = urg_cnt_ff + CNT_BITS'(1);
               end
            end else begin
               if (nrm_cnt_ff == CNT_FULL) begin
                  status_in = tcspq_pkg::STATUS_FULL;
               end else begin
                  nrm_we      = 1'b1;
                  nrm_tail_in = (nrm_tail_ff == PTR_LAST) ? '0 :
                                nrm_tail_ff + PTR_BITS'(1);
                  nrm_cnt_in  = nrm_cnt_ff + CNT_BITS'(1);
               end
            end
         end
         tcspq_pkg::OP_DEQUEUE, tcspq_pkg::OP_PEEK: begin
            priority if (urg_cnt_ff != '0) begin
               out_id_in    = tcspq_pkg::ITEM_ID_BITS'(urg_rd_ff);
               out_class_in = 1'b1;
               if (op_ff == tcspq_pkg::OP_DEQUEUE) begin
                  urg_head_in = (urg_head_ff == PTR_LAST) ? '0 :
                                urg_head_ff + PTR_BITS'(1);
                  urg_cnt_in  = urg_cnt_ff - CNT_BITS'(1);
               end
            end else if (nrm_cnt_ff != '0) begin
               out_id_in = tcspq_pkg::ITEM_ID_BITS'(nrm_rd_ff);
               if (op_ff == tcspq_pkg::OP_DEQUEUE) begin
                  nrm_head_in = (nrm_head_ff == PTR_LAST) ? '0 :
                                nrm_head_ff + PTR_BITS'(1);
                  nrm_cnt_in  = nrm_cnt_ff - CNT_BITS'(1);
               end
            end else begin
               status_in = tcspq_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            status_in = tcspq_pkg::STATUS_OK;
         end
      endcase
      // Nothing above takes effect unless the result is being committed.
      if (!cmd.commit) begin
         urg_head_in = urg_head_ff;
         urg_tail_in = urg_tail_ff;
         urg_cnt_in  = urg_cnt_ff;
         nrm_head_in = nrm_head_ff;
         nrm_tail_in = nrm_tail_ff;
         nrm_cnt_in  = nrm_cnt_ff;
         urg_we      = 1'b0;
         nrm_we      = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         urg_head_ff  <= '0;
         urg_tail_ff  <= '0;
         urg_cnt_ff   <= '0;
         nrm_head_ff  <= '0;
         nrm_tail_ff  <= '0;
         nrm_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         urg_head_ff  <= urg_head_in;
         urg_tail_ff  <= urg_tail_in;
         urg_cnt_ff   <= urg_cnt_in;
         nrm_head_ff  <= nrm_head_in;
         nrm_tail_ff  <= nrm_tail_in;
         nrm_cnt_ff   <= nrm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_id_ff    <= out_id_in;
         out_class_ff <= out_class_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_out_id    = out_id_ff;
   assign rsp_out_class = out_class_ff;
   assign rsp_status    = status_ff;

endmodule

@@ rtl/two_class_strict_priority_queue.sv @@
// Two-class strict-priority queue of item identifiers.
// Each request item on the req_ channel carries an opcode (enqueue, dequeue
// or peek), a class for enqueue and an identifier. Enqueue appends to the
// urgent or the normal FIFO; dequeue and peek take the oldest urgent item
// if there is one, otherwise the oldest normal item. Every request item
// gives exactly one response item on the rsp_ channel with the identifier,
// its class and a status (ok, both FIFOs empty, or target FIFO full).
// The request passes through the sequencer's read and commit steps before its
// response is registered as valid. The sequencer takes the registered read of
// the FIFO heads and then the commit, and accepts no new request meanwhile.
// Only one item is in flight; req_tready is high while the sequencer idles.
// A finished response sits in an output register, so a new request can be
// accepted while it waits. When the receiver stalls, the next item holds in
// its commit step until the output register is free.
// Reset empties both FIFOs at once; stored entries are never read before
// they are written, so the storage needs no clearing.
module two_class_strict_priority_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item_id
   input  logic [2:0]  req_tuser,   // opcode[1:0], item_class[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_id
   output logic [2:0]  rsp_tuser    // out_class[0], status[2:1]
);

   tcspq_pkg::ctl_cmd_type   cmd;
   tcspq_pkg::dp_status_type dp_status;
   logic                     out_class;
   logic [1:0]               status;

   tcspq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   tcspq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_status      (dp_status),
      .req_opcode     (req_tuser[1:0]),
      .req_item_class (req_tuser[2]),
      .req_item_id    (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_out_id     (rsp_tdata),
      .rsp_out_class  (out_class),
      .rsp_status     (status)
   );

   assign rsp_tuser = {status, out_class};

endmodule
